>>> sv/vnf_pkg.sv
`timescale 1ns / 1ps
// shared constants, hash keys and beat types for the fractal value noise block
package vnf_pkg;

  localparam int MAX_OCTAVES_DEF = 8;
  localparam int CNT_W           = 5;
  localparam int AMP_W           = 17;
  localparam int CELL_W          = 32;
  localparam int FRAC_W          = 16;
  localparam int U_W             = 16;
  localparam int Q_W             = 16;
  localparam int DIV_STAGES      = 4;
  localparam int DIV_STEP        = Q_W / DIV_STAGES;
  localparam int CFG_IDX_W       = 3;

  localparam logic [AMP_W-1:0] AMP_ONE = 17'h10000;
  localparam logic [16:0]      U_MID   = 17'd32768;

  localparam logic [21:0] HASH_KX = 22'd3747613;
  localparam logic [22:0] HASH_KZ = 23'd6682651;
  localparam logic [23:0] HASH_KS = 24'd9876543;
  localparam logic [23:0] MIX_K1  = 24'd12741261;
  localparam logic [29:0] MIX_K2  = 30'd1013904223;

  localparam logic [CFG_IDX_W-1:0] CFG_SEED    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OCTAVES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERSIST = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE   = 3'd3;

  typedef struct packed {
    logic [AMP_W-1:0] amp;
    logic             first;
    logic             last;
  } side_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_x;
    logic [CELL_W-1:0] cell_z;
    logic [FRAC_W-1:0] frac_x;
    logic [FRAC_W-1:0] frac_z;
    side_t             side;
  } oct_beat_t;

  typedef struct packed {
    logic [U_W-1:0] u00;
    logic [U_W-1:0] u10;
    logic [U_W-1:0] u01;
    logic [U_W-1:0] u11;
    logic [15:0]    sx;
    logic [15:0]    sz;
    side_t          side;
  } corner_beat_t;

endpackage

>>> sv/vnf_seq.sv
`timescale 1ns / 1ps
// input stage: coordinate scaling and per-octave beat issue with amplitude update
module vnf_seq import vnf_pkg::*; #(
  parameter int MAX_OCTAVES = MAX_OCTAVES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_z,
  input  logic [3:0]         octave_count,
  input  logic [16:0]        persistence,
  input  logic [23:0]        base_scale,
  output logic               oct_valid,
  input  logic               oct_ready,
  output oct_beat_t          oct_beat
);

  localparam int OCT_W = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;

  logic               item_v_r;
  logic signed [56:0] px_r, pz_r;
  logic signed [56:0] px_nxt, pz_nxt;
  logic [OCT_W-1:0]   oct_r;
  logic [AMP_W-1:0]   amp_r;
  logic [AMP_W-1:0]   amp_nxt;
  logic [AMP_W-1:0]   pers;
  logic [33:0]        amp_prod;
  logic [CNT_W-1:0]   ncnt;
  logic [CNT_W-1:0]   oc;
  logic               oct_v_r;
  oct_beat_t          beat_r;
  oct_beat_t          beat_nxt;
  logic [63:0]        ax, az;
  logic               issue_en, issue, last, take;

  always_comb begin
    oc = {1'b0, octave_count};
    if (oc == '0) begin
      ncnt = CNT_W'(1);
    end else if (oc > CNT_W'(MAX_OCTAVES)) begin
      ncnt = CNT_W'(MAX_OCTAVES);
    end else begin
      ncnt = oc;
    end
    pers     = (persistence > AMP_ONE) ? AMP_ONE : persistence;
    amp_prod = 34'(amp_r) * 34'(pers);
    amp_nxt  = amp_prod[32:16];
    px_nxt   = coord_x * $signed({1'b0, base_scale});
    pz_nxt   = coord_z * $signed({1'b0, base_scale});
    ax       = {{7{px_r[56]}}, px_r} << oct_r;
    az       = {{7{pz_r[56]}}, pz_r} << oct_r;
    last     = (CNT_W'(oct_r) + CNT_W'(1)) == ncnt;
    issue_en = !oct_v_r || oct_ready;
    issue    = item_v_r && issue_en;
    in_ready = !item_v_r || (issue_en && last);
    take     = in_valid && in_ready;
    beat_nxt.cell_x     = ax[63:32];
    beat_nxt.cell_z     = az[63:32];
    beat_nxt.frac_x     = ax[31:16];
    beat_nxt.frac_z     = az[31:16];
    beat_nxt.side.amp   = amp_r;
    beat_nxt.side.first = (oct_r == '0);
    beat_nxt.side.last  = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
      oct_v_r  <= 1'b0;
    end else begin
      if (issue_en) begin
        oct_v_r <= item_v_r;
      end
      if (take) begin
        item_v_r <= 1'b1;
      end else if (issue && last) begin
        item_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      px_r  <= px_nxt;
      pz_r  <= pz_nxt;
      oct_r <= '0;
      amp_r <= AMP_ONE;
    end else if (issue) begin
      oct_r <= oct_r + OCT_W'(1);
      amp_r <= amp_nxt;
    end
    if (issue) begin
      beat_r <= beat_nxt;
    end
  end

  assign oct_valid = oct_v_r;
  assign oct_beat  = beat_r;

endmodule

>>> sv/vnf_hash.sv
`timescale 1ns / 1ps
// six-stage corner hash pipeline with smoothstep weights alongside
module vnf_hash import vnf_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic [31:0]  seed,
  input  logic         up_valid,
  output logic         up_ready,
  input  oct_beat_t    up_beat,
  output logic         dn_valid,
  input  logic         dn_ready,
  output corner_beat_t dn_beat
);

  function automatic logic [15:0] smooth16(input logic [15:0] f, input logic [31:0] f2);
    logic [33:0] p;
    p = 34'(f2[31:16]) * (34'(18'd196608) - 34'({f, 1'b0}));
    return p[31:16];
  endfunction

  logic [6:1] v_r;
  logic [6:1] en;
  side_t      side_r [1:6];

  logic [15:0]        fx_r, fz_r;
  logic [31:0]        fx2_r, fz2_r;
  logic signed [55:0] px_r [2];
  logic signed [55:0] pz_r [2];
  logic signed [55:0] ps_r;
  logic signed [55:0] px_nxt [2];
  logic signed [55:0] pz_nxt [2];
  logic signed [55:0] ps_nxt;
  logic [31:0]        cx1, cz1;

  logic [15:0] sx_r [2:6];
  logic [15:0] sz_r [2:6];

  logic [63:0] g_r   [4];
  logic [63:0] g_nxt [4];
  logic [55:0] lo1_r [4];
  logic [55:0] lo1_nxt [4];
  logic [31:0] hi1_r [4];
  logic [31:0] hi1_nxt [4];
  logic [63:0] m_r   [4];
  logic [63:0] m_nxt [4];
  logic [61:0] lo2_r [4];
  logic [61:0] lo2_nxt [4];
  logic [31:0] hi2_r [4];
  logic [31:0] hi2_nxt [4];
  logic [15:0] u_r   [4];
  logic [15:0] u_nxt [4];

  always_comb begin
    en[6] = !v_r[6] || dn_ready;
    for (int k = 5; k >= 1; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign up_ready = en[1];

  always_comb begin
    logic [63:0] h;
    logic [55:0] t56;
    logic [61:0] t62;
    cx1       = up_beat.cell_x + 32'd1;
    cz1       = up_beat.cell_z + 32'd1;
    px_nxt[0] = $signed(up_beat.cell_x) * $signed({1'b0, HASH_KX});
    px_nxt[1] = $signed(cx1) * $signed({1'b0, HASH_KX});
    pz_nxt[0] = $signed(up_beat.cell_z) * $signed({1'b0, HASH_KZ});
    pz_nxt[1] = $signed(cz1) * $signed({1'b0, HASH_KZ});
    ps_nxt    = $signed(seed) * $signed({1'b0, HASH_KS});
    for (int c = 0; c < 4; c++) begin
      h = {{8{px_r[c & 1][55]}}, px_r[c & 1]}
        + {{8{pz_r[c >> 1][55]}}, pz_r[c >> 1]}
        + {{8{ps_r[55]}}, ps_r};
      g_nxt[c]   = h ^ 64'($signed(h) >>> 13);
      lo1_nxt[c] = g_r[c][31:0] * MIX_K1;
      t56        = g_r[c][63:32] * MIX_K1;
      hi1_nxt[c] = t56[31:0];
      h          = {hi1_r[c], 32'd0} + {8'd0, lo1_r[c]};
      m_nxt[c]   = h ^ 64'($signed(h) >>> 17);
      lo2_nxt[c] = m_r[c][31:0] * MIX_K2;
      t62        = m_r[c][63:32] * MIX_K2;
      hi2_nxt[c] = t62[31:0];
      h          = {hi2_r[c], 32'd0} + {2'd0, lo2_r[c]};
      h          = h ^ 64'($signed(h) >>> 13);
      u_nxt[c]   = h[30:15];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) begin
        v_r[1] <= up_valid;
      end
      for (int k = 2; k <= 6; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      side_r[1] <= up_beat.side;
      px_r      <= px_nxt;
      pz_r      <= pz_nxt;
      ps_r      <= ps_nxt;
      fx_r      <= up_beat.frac_x;
      fz_r      <= up_beat.frac_z;
      fx2_r     <= up_beat.frac_x * up_beat.frac_x;
      fz2_r     <= up_beat.frac_z * up_beat.frac_z;
    end
    if (en[2]) begin
      side_r[2] <= side_r[1];
      sx_r[2]   <= smooth16(fx_r, fx2_r);
      sz_r[2]   <= smooth16(fz_r, fz2_r);
      g_r       <= g_nxt;
    end
    if (en[3]) begin
      lo1_r <= lo1_nxt;
      hi1_r <= hi1_nxt;
    end
    if (en[4]) begin
      m_r <= m_nxt;
    end
    if (en[5]) begin
      lo2_r <= lo2_nxt;
      hi2_r <= hi2_nxt;
    end
    if (en[6]) begin
      u_r <= u_nxt;
    end
    for (int k = 3; k <= 6; k++) begin
      if (en[k]) begin
        side_r[k] <= side_r[k-1];
        sx_r[k]   <= sx_r[k-1];
        sz_r[k]   <= sz_r[k-1];
      end
    end
  end

  assign dn_valid     = v_r[6];
  assign dn_beat.u00  = u_r[0];
  assign dn_beat.u10  = u_r[1];
  assign dn_beat.u01  = u_r[2];
  assign dn_beat.u11  = u_r[3];
  assign dn_beat.sx   = sx_r[6];
  assign dn_beat.sz   = sz_r[6];
  assign dn_beat.side = side_r[6];

endmodule

>>> sv/vnf_blend.sv
`timescale 1ns / 1ps
// bilinear blend, amplitude weighting and octave accumulation
module vnf_blend import vnf_pkg::*; #(
  parameter int MAX_OCTAVES = MAX_OCTAVES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    up_valid,
  output logic                    up_ready,
  input  corner_beat_t            up_beat,
  output logic                    dn_valid,
  input  logic                    dn_ready,
  output logic signed [17 + $clog2(MAX_OCTAVES) + 18 - 1:0] dn_total,
  output logic [17 + $clog2(MAX_OCTAVES) - 1:0]             dn_norm
);

  localparam int NORM_W = 17 + $clog2(MAX_OCTAVES);
  localparam int TOT_W  = NORM_W + 18;

  function automatic logic [15:0] lerp16(input logic [15:0] a, input logic [15:0] b,
                                         input logic [15:0] s);
    logic signed [16:0] d;
    logic signed [33:0] p;
    logic signed [16:0] t;
    logic signed [16:0] r;
    d = $signed({1'b0, b}) - $signed({1'b0, a});
    p = d * $signed({1'b0, s});
    t = 17'(p >>> 16);
    r = $signed({1'b0, a}) + t;
    return r[15:0];
  endfunction

  logic [3:1]         v_r;
  logic [4:1]         en;
  side_t              side_r [1:3];
  logic [15:0]        nx0_r, nx1_r, sz_r;
  logic signed [16:0] val_r;
  logic [15:0]        n_c;
  logic signed [34:0] term_r;
  logic               ov_r;
  logic signed [TOT_W-1:0]  acc_r, acc_nxt;
  logic [NORM_W-1:0]        nacc_r, nacc_nxt;

  always_comb begin
    en[4] = !ov_r || dn_ready;
    for (int k = 3; k >= 1; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    n_c = lerp16(nx0_r, nx1_r, sz_r);
    if (side_r[3].first) begin
      acc_nxt  = TOT_W'(term_r);
      nacc_nxt = NORM_W'(side_r[3].amp);
    end else begin
      acc_nxt  = acc_r + TOT_W'(term_r);
      nacc_nxt = nacc_r + NORM_W'(side_r[3].amp);
    end
  end

  assign up_ready = en[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= '0;
      ov_r <= 1'b0;
    end else begin
      if (en[1]) begin
        v_r[1] <= up_valid;
      end
      if (en[2]) begin
        v_r[2] <= v_r[1];
      end
      if (en[3]) begin
        v_r[3] <= v_r[2];
      end
      if (en[4]) begin
        ov_r <= v_r[3] && side_r[3].last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      nx0_r     <= lerp16(up_beat.u00, up_beat.u10, up_beat.sx);
      nx1_r     <= lerp16(up_beat.u01, up_beat.u11, up_beat.sx);
      sz_r      <= up_beat.sz;
      side_r[1] <= up_beat.side;
    end
    if (en[2]) begin
      val_r     <= $signed({1'b0, n_c}) - $signed(U_MID);
      side_r[2] <= side_r[1];
    end
    if (en[3]) begin
      term_r    <= val_r * $signed({1'b0, side_r[2].amp});
      side_r[3] <= side_r[2];
    end
    if (en[4] && v_r[3]) begin
      acc_r  <= acc_nxt;
      nacc_r <= nacc_nxt;
    end
  end

  assign dn_valid = ov_r;
  assign dn_total = acc_r;
  assign dn_norm  = nacc_r;

endmodule

>>> sv/vnf_div.sv
`timescale 1ns / 1ps
// pipelined restoring divider for normalization, with saturation and output register
module vnf_div import vnf_pkg::*; #(
  parameter int MAX_OCTAVES = MAX_OCTAVES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    up_valid,
  output logic                    up_ready,
  input  logic signed [17 + $clog2(MAX_OCTAVES) + 18 - 1:0] up_total,
  input  logic [17 + $clog2(MAX_OCTAVES) - 1:0]             up_norm,
  output logic                    dn_valid,
  input  logic                    dn_ready,
  output logic signed [15:0]      dn_value
);

  localparam int NORM_W = 17 + $clog2(MAX_OCTAVES);
  localparam int TOT_W  = NORM_W + 18;
  localparam int REM_W  = NORM_W + Q_W;
  localparam int LAST   = DIV_STAGES + 1;

  logic [LAST:0]       v_r;
  logic [LAST:0]       en;
  logic                sg_r  [DIV_STAGES+1];
  logic [REM_W-1:0]    rem_r [DIV_STAGES+1];
  logic [Q_W-1:0]      q_r   [DIV_STAGES+1];
  logic [NORM_W-1:0]   nm_r  [DIV_STAGES+1];
  logic [REM_W-1:0]    rem_nxt [DIV_STAGES+1];
  logic [Q_W-1:0]      q_nxt   [DIV_STAGES+1];
  logic [TOT_W-1:0]    mag;
  logic [15:0]         res_c;
  logic [15:0]         qf;
  logic signed [15:0]  val_r;

  always_comb begin
    en[LAST] = !v_r[LAST] || dn_ready;
    for (int k = LAST - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign up_ready = en[0];

  always_comb begin
    logic [REM_W-1:0] r;
    logic [Q_W-1:0]   q;
    logic [REM_W-1:0] t;
    mag        = up_total[TOT_W-1] ? TOT_W'(-up_total) : TOT_W'(up_total);
    rem_nxt[0] = mag[REM_W-1:0];
    q_nxt[0]   = '0;
    for (int k = 1; k <= DIV_STAGES; k++) begin
      r = rem_r[k-1];
      q = q_r[k-1];
      for (int j = 0; j < DIV_STEP; j++) begin
        t = REM_W'(nm_r[k-1]) << (Q_W - 1 - (k - 1) * DIV_STEP - j);
        if (r >= t) begin
          r = r - t;
          q[Q_W - 1 - (k - 1) * DIV_STEP - j] = 1'b1;
        end
      end
      rem_nxt[k] = r;
      q_nxt[k]   = q;
    end
    qf = q_r[DIV_STAGES];
    if (sg_r[DIV_STAGES]) begin
      res_c = (qf > 16'h8000) ? 16'h8000 : 16'(-qf);
    end else begin
      res_c = (qf > 16'h7fff) ? 16'h7fff : qf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= up_valid;
      end
      for (int k = 1; k <= LAST; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sg_r[0]  <= up_total[TOT_W-1];
      rem_r[0] <= rem_nxt[0];
      q_r[0]   <= q_nxt[0];
      nm_r[0]  <= up_norm;
    end
    for (int k = 1; k <= DIV_STAGES; k++) begin
      if (en[k]) begin
        sg_r[k]  <= sg_r[k-1];
        rem_r[k] <= rem_nxt[k];
        q_r[k]   <= q_nxt[k];
        nm_r[k]  <= nm_r[k-1];
      end
    end
    if (en[LAST]) begin
      val_r <= res_c;
    end
  end

  assign dn_valid = v_r[LAST];
  assign dn_value = val_r;

endmodule

>>> sv/value_noise_2d_fractal.sv
`timescale 1ns / 1ps
// top level: fractal 2d value noise, config registers and pipeline wiring
//
//   channel  signals                               dir  notes
//   in       in_valid/in_ready, in_coord_x/z       in   signed q16.16 coordinate pair
//   out      out_valid/out_ready, out_noise_value  out  signed q1.15 noise sample
//   cfg      cfg_we, cfg_index, cfg_wdata          in   seed, octaves, persistence, scale
//
// one item takes n beats of issue, n = octave count clamped to 1..MAX_OCTAVES: the
// sequencer sends one octave per cycle into the shared hash and blend pipeline while
// the hash stage is ready to take it
// rst_n is synchronous, clears all valid bits and sets the config registers to their defaults
// every stage holds under a stall and bubbles close up, so input keeps flowing
// while an output beat waits, until the empty stages ahead have filled
module value_noise_2d_fractal import vnf_pkg::*; #(
  parameter int MAX_OCTAVES = MAX_OCTAVES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [31:0]   in_coord_x,
  input  logic signed [31:0]   in_coord_z,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [15:0]   out_noise_value,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata
);

  localparam int NORM_W = 17 + $clog2(MAX_OCTAVES);
  localparam int TOT_W  = NORM_W + 18;

  logic [31:0] seed_r;
  logic [3:0]  octaves_r;
  logic [16:0] persist_r;
  logic [23:0] scale_r;

  logic         oct_valid, oct_ready;
  oct_beat_t    oct_beat;
  logic         cor_valid, cor_ready;
  corner_beat_t cor_beat;
  logic         sum_valid, sum_ready;
  logic signed [TOT_W-1:0] sum_total;
  logic [NORM_W-1:0]       sum_norm;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r    <= 32'd0;
      octaves_r <= 4'd4;
      persist_r <= 17'd32768;
      scale_r   <= 24'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SEED:    seed_r    <= cfg_wdata;
        CFG_OCTAVES: octaves_r <= cfg_wdata[3:0];
        CFG_PERSIST: persist_r <= cfg_wdata[16:0];
        CFG_SCALE:   scale_r   <= cfg_wdata[23:0];
        default: begin
        end
      endcase
    end
  end

  vnf_seq #(.MAX_OCTAVES(MAX_OCTAVES)) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .coord_x      (in_coord_x),
    .coord_z      (in_coord_z),
    .octave_count (octaves_r),
    .persistence  (persist_r),
    .base_scale   (scale_r),
    .oct_valid    (oct_valid),
    .oct_ready    (oct_ready),
    .oct_beat     (oct_beat)
  );

  vnf_hash u_hash (
    .clk      (clk),
    .rst_n    (rst_n),
    .seed     (seed_r),
    .up_valid (oct_valid),
    .up_ready (oct_ready),
    .up_beat  (oct_beat),
    .dn_valid (cor_valid),
    .dn_ready (cor_ready),
    .dn_beat  (cor_beat)
  );

  vnf_blend #(.MAX_OCTAVES(MAX_OCTAVES)) u_blend (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (cor_valid),
    .up_ready (cor_ready),
    .up_beat  (cor_beat),
    .dn_valid (sum_valid),
    .dn_ready (sum_ready),
    .dn_total (sum_total),
    .dn_norm  (sum_norm)
  );

  vnf_div #(.MAX_OCTAVES(MAX_OCTAVES)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (sum_valid),
    .up_ready (sum_ready),
    .up_total (sum_total),
    .up_norm  (sum_norm),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_value (out_noise_value)
  );

endmodule
